// ===== rtl/md5cr_pkg.sv =====
// shared types, constants and helper functions for the keyed md5 challenge-response unit
// no dependencies; used by the interfaces, the round stage and the top level
package md5cr_pkg;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} md5_state_t;

	// what travels down the round pipeline with each item
	typedef struct packed {
		md5_state_t   st;
		logic [127:0] msg;
	} md5cr_pipe_t;

	// register index as carried on the configuration channel
	typedef logic [7:0] cfg_idx_t;

	typedef enum cfg_idx_t {
		REG_SEED_LOW  = 8'd0,
		REG_SEED_HIGH = 8'd1
	} cfg_reg_t;

	localparam int NUM_ROUNDS = 64;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	// padded block: message words 0..3, pad marker in word 4, bit length in word 14
	localparam logic [3:0]  WORD_PAD_IDX = 4'd4;
	localparam logic [3:0]  WORD_LEN_IDX = 4'd14;
	localparam logic [31:0] PAD_WORD     = 32'h00000080;
	localparam logic [31:0] LEN_WORD     = 32'd128;

	localparam logic [31:0] K_TABLE [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_TABLE [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22,
		5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23,
		5'd6, 5'd10, 5'd15, 5'd21
	};

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] t;
		t = {x, x} << s;
		return t[63:32];
	endfunction

	// message word used by a given round
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] i4;
		logic [3:0] w;
		i4 = rnd[3:0];
		case (rnd[5:4])
			2'd0: w = i4;
			2'd1: w = 4'(i4 * 4'd5 + 4'd1);
			2'd2: w = 4'(i4 * 4'd3 + 4'd5);
			default: w = 4'(i4 * 4'd7);
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/md5cr_if.sv =====
// valid/ready channel interfaces for challenge, response and configuration items
// depends on md5cr_pkg
interface md5cr_chal_if;
	logic        valid;
	logic        ready;
	logic [63:0] challenge_low;
	logic [63:0] challenge_high;

	modport source (output valid, challenge_low, challenge_high, input ready);
	modport sink   (input valid, challenge_low, challenge_high, output ready);
endinterface

interface md5cr_resp_if;
	logic        valid;
	logic        ready;
	logic [63:0] response_low;
	logic [63:0] response_high;

	modport source (output valid, response_low, response_high, input ready);
	modport sink   (input valid, response_low, response_high, output ready);
endinterface

interface md5cr_cfg_if;
	logic                 valid;
	logic                 ready;
	md5cr_pkg::cfg_idx_t  index;
	logic [63:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/md5cr_round.sv =====
// one md5 round with its pipeline register
// depends on md5cr_pkg
module md5cr_round (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [5:0]             rnd,
	input  logic                   valid_in,
	input  md5cr_pkg::md5cr_pipe_t data_in,
	output logic                   valid_s1,
	output md5cr_pkg::md5cr_pipe_t data_s1
);
	import md5cr_pkg::*;

	logic [31:0] f;
	logic [31:0] m;
	logic [3:0]  w;
	logic [31:0] sum;
	logic [31:0] new_b;
	md5_state_t  st;
	md5_state_t  nxt;

	assign st = data_in.st;
	assign w  = msg_index(rnd);

	always_comb begin
		case (rnd[5:4])
			2'd0: f = (st.b & st.c) | (~st.b & st.d);
			2'd1: f = (st.d & st.b) | (~st.d & st.c);
			2'd2: f = st.b ^ st.c ^ st.d;
			default: f = st.c ^ (st.b | ~st.d);
		endcase
	end

	always_comb begin
		case (w)
			4'd0: m = data_in.msg[31:0];
			4'd1: m = data_in.msg[63:32];
			4'd2: m = data_in.msg[95:64];
			4'd3: m = data_in.msg[127:96];
			WORD_PAD_IDX: m = PAD_WORD;
			WORD_LEN_IDX: m = LEN_WORD;
			default: m = '0;
		endcase
	end

	assign sum   = st.a + f + K_TABLE[rnd] + m;
	assign new_b = st.b + rotl32(sum, ROT_TABLE[{rnd[5:4], rnd[1:0]}]);

	always_comb begin
		nxt.a = st.d;
		nxt.b = new_b;
		nxt.c = st.b;
		nxt.d = st.c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.st  <= nxt;
			data_s1.msg <= data_in.msg;
		end
	end

endmodule

// ===== rtl/seeded_md5_challenge_response_unit.sv =====
// top level of the keyed md5 challenge-response unit: seed registers, round pipeline, output
// depends on md5cr_pkg, md5cr_if (channel interfaces) and md5cr_round
//
// each challenge item is xored with the 128-bit seed and hashed as one padded md5 block
// (message length 128 bits); the 16-byte digest comes back as one response item. the
// datapath is a 66-stage pipeline: one input stage that forms the message, one stage per
// md5 round (64), and an output register that adds the initial chaining values. one item
// is accepted every cycle while the response side takes items. the whole pipeline
// advances together: it holds only while a response waits in the output register and
// the sink is not ready. seed writes are taken in any cycle and apply to items accepted
// afterwards.
module seeded_md5_challenge_response_unit (
	input  logic               clk,
	input  logic               arst_n,
	md5cr_chal_if.sink         challenge,
	md5cr_resp_if.source       response,
	md5cr_cfg_if.sink          cfg
);
	import md5cr_pkg::*;

	// seed registers
	logic [63:0] seed_low_q;
	logic [63:0] seed_high_q;

	// pipeline advance for all stages
	logic en;

	// input stage
	logic        valid_s0;
	md5cr_pipe_t data_s0;

	// round stages, index k holds the output of round k
	logic        rvalid [NUM_ROUNDS];
	md5cr_pipe_t rdata  [NUM_ROUNDS];

	// output register
	logic        out_valid_q;
	logic [63:0] out_low_q;
	logic [63:0] out_high_q;

	md5_state_t  fin;

	assign en              = !out_valid_q || response.ready;
	assign challenge.ready = en;
	assign cfg.ready       = 1'b1;

	// configuration writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q  <= '0;
			seed_high_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SEED_LOW:  seed_low_q  <= cfg.data;
				REG_SEED_HIGH: seed_high_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input stage: keyed message and initial state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= challenge.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s0.msg  <= {challenge.challenge_high ^ seed_high_q,
				challenge.challenge_low ^ seed_low_q};
			data_s0.st.a <= IV_A;
			data_s0.st.b <= IV_B;
			data_s0.st.c <= IV_C;
			data_s0.st.d <= IV_D;
		end
	end

	// 64 round stages
	for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_round
		if (k == 0) begin : g_first
			md5cr_round u_round (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.rnd      (6'(k)),
				.valid_in (valid_s0),
				.data_in  (data_s0),
				.valid_s1 (rvalid[k]),
				.data_s1  (rdata[k])
			);
		end else begin : g_next
			md5cr_round u_round (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.rnd      (6'(k)),
				.valid_in (rvalid[k-1]),
				.data_in  (rdata[k-1]),
				.valid_s1 (rvalid[k]),
				.data_s1  (rdata[k])
			);
		end
	end

	// final chaining add
	always_comb begin
		fin.a = rdata[NUM_ROUNDS-1].st.a + IV_A;
		fin.b = rdata[NUM_ROUNDS-1].st.b + IV_B;
		fin.c = rdata[NUM_ROUNDS-1].st.c + IV_C;
		fin.d = rdata[NUM_ROUNDS-1].st.d + IV_D;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= rvalid[NUM_ROUNDS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_low_q  <= {fin.b, fin.a};
			out_high_q <= {fin.d, fin.c};
		end
	end

	assign response.valid         = out_valid_q;
	assign response.response_low  = out_low_q;
	assign response.response_high = out_high_q;

endmodule
